### rtl/fdos_pkg.sv
package fdos_pkg;

  localparam int MAX_VERTS = 4;
  localparam int LANES     = 4;
  localparam int VERT_TOP  = (MAX_VERTS < LANES) ? MAX_VERTS : LANES;

  localparam int FACE_W = 16;
  localparam int DIST_W = 24;
  localparam int CNTV_W = 3;
  localparam int SUM_W  = DIST_W + 2;

  // x / 3 == (x * ceil(2^29 / 3)) >> 29 for x < 2^27
  localparam int                RECIP3_W     = 28;
  localparam logic [RECIP3_W-1:0] RECIP3     = 28'hAAAAAAB;
  localparam int                RECIP3_SHIFT = 29;
  localparam int                PROD_W       = SUM_W + RECIP3_W;

  typedef struct packed {
    logic [FACE_W-1:0] face_ident;
    logic [CNTV_W-1:0] vertex_count;
    logic [DIST_W-1:0] distance_0;
    logic [DIST_W-1:0] distance_1;
    logic [DIST_W-1:0] distance_2;
    logic [DIST_W-1:0] distance_3;
    logic              final_face;
  } fdos_in_t;

  typedef struct packed {
    logic [FACE_W-1:0] sorted_face;
    logic [DIST_W-1:0] nearest_distance;
    logic              dropped;
    logic              list_end;
  } fdos_out_t;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [DIST_W-1:0] nearest;
    logic [DIST_W-1:0] average;
  } fdos_entry_t;

  typedef struct packed {
    fdos_entry_t entry;
    logic        final_face;
  } fdos_ins_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } fdos_ctl_t;

endpackage

### rtl/fdos_front.sv
module fdos_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  fdos_pkg::fdos_in_t in_data,
  output logic               ins_valid,
  output fdos_pkg::fdos_ins_t ins,
  output logic               final_pending
);
  import fdos_pkg::*;

  logic [CNTV_W-1:0] lanes;
  logic [DIST_W-1:0] lane_d [LANES];
  logic [DIST_W-1:0] dmin [LANES];
  logic [DIST_W-1:0] dsum [LANES];
  logic [DIST_W-1:0] min01, min23, near_c;
  logic [SUM_W-1:0]  sum_c;

  logic              s1_valid_r;
  logic [FACE_W-1:0] s1_face_r;
  logic [DIST_W-1:0] s1_near_r;
  logic [SUM_W-1:0]  s1_sum_r;
  logic [CNTV_W-1:0] s1_lanes_r;
  logic              s1_final_r;

  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] avg_c;
  logic              ins_valid_r;
  fdos_ins_t         ins_r;

  assign lane_d[0] = in_data.distance_0;
  assign lane_d[1] = in_data.distance_1;
  assign lane_d[2] = in_data.distance_2;
  assign lane_d[3] = in_data.distance_3;

  always_comb begin
    lanes = in_data.vertex_count;
    if (lanes == '0) lanes = CNTV_W'(1);
    if (lanes > CNTV_W'(VERT_TOP)) lanes = CNTV_W'(VERT_TOP);
    for (int i = 0; i < LANES; i++) begin
      if (CNTV_W'(i) < lanes) begin
        dmin[i] = lane_d[i];
        dsum[i] = lane_d[i];
      end else begin
        dmin[i] = '1;
        dsum[i] = '0;
      end
    end
  end

  assign min01  = (dmin[1] < dmin[0]) ? dmin[1] : dmin[0];
  assign min23  = (dmin[3] < dmin[2]) ? dmin[3] : dmin[2];
  assign near_c = (min23 < min01) ? min23 : min01;
  assign sum_c  = (SUM_W'(dsum[0]) + SUM_W'(dsum[1])) + (SUM_W'(dsum[2]) + SUM_W'(dsum[3]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_face_r  <= in_data.face_ident;
      s1_near_r  <= near_c;
      s1_sum_r   <= sum_c;
      s1_lanes_r <= lanes;
      s1_final_r <= in_data.final_face;
    end
  end

  assign prod = PROD_W'(s1_sum_r) * PROD_W'(RECIP3);

  always_comb begin
    case (s1_lanes_r)
      3'd1:    avg_c = s1_sum_r[DIST_W-1:0];
      3'd2:    avg_c = s1_sum_r[DIST_W:1];
      3'd3:    avg_c = prod[RECIP3_SHIFT +: DIST_W];
      3'd4:    avg_c = s1_sum_r[DIST_W+1:2];
      default: avg_c = s1_sum_r[DIST_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_valid_r <= 1'b0;
    end else begin
      ins_valid_r <= s1_valid_r;
    end
    if (s1_valid_r) begin
      ins_r.entry.face    <= s1_face_r;
      ins_r.entry.nearest <= s1_near_r;
      ins_r.entry.average <= avg_c;
      ins_r.final_face    <= s1_final_r;
    end
  end

  assign ins_valid     = ins_valid_r;
  assign ins           = ins_r;
  assign final_pending = (s1_valid_r & s1_final_r) | (ins_valid_r & ins_r.final_face);

endmodule

### rtl/fdos_cell.sv
module fdos_cell (
  input  logic                  clk,
  input  fdos_pkg::fdos_ctl_t   ctl,
  input  logic                  occupied,
  input  fdos_pkg::fdos_entry_t new_entry,
  input  fdos_pkg::fdos_entry_t prev_entry,
  input  logic                  prev_ahead,
  input  fdos_pkg::fdos_entry_t next_entry,
  output fdos_pkg::fdos_entry_t entry,
  output logic                  ahead
);
  import fdos_pkg::*;

  fdos_entry_t entry_r, entry_nxt;

  // new face goes ahead of this entry
  assign ahead = !occupied
               | (new_entry.nearest > entry_r.nearest)
               | ((new_entry.nearest == entry_r.nearest)
                  & (new_entry.average >= entry_r.average));

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (prev_ahead) begin
        entry_nxt = prev_entry;
      end else if (ahead) begin
        entry_nxt = new_entry;
      end
    end else if (ctl.shift) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

### rtl/face_depth_order_sorter_top.sv
// Face depth-order sorter.
// Input channel (in_valid / in_stall / in_data): one face per transaction,
// accepted when in_valid is high and in_stall is low. Up to one face per
// cycle is taken while no set end is in flight.
// Each face gets its nearest vertex distance and truncated lane average
// in a two-stage front end, then is inserted at the next edge into a row
// of MAX_FACES cells kept sorted farthest first; every cell compares the
// new face in parallel and takes it, its left neighbor's entry or its own.
// A face with final_face set closes the set: in_stall rises from its
// acceptance until the last entry of the list has been taken. The first
// result is valid once the final face has passed both front-end stages
// and been inserted, then one entry per cycle, while out_stall is low, is
// shifted out of cell 0 (out_valid / out_stall / out_data). Faces arriving
// while the list is full are dropped and flagged.
// When out_stall is high the list simply holds; out_data stays stable.
// Reset (rst_n low, synchronous) empties the list and clears the drop flag.
module face_depth_order_sorter_top #(
  parameter int MAX_FACES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fdos_pkg::fdos_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fdos_pkg::fdos_out_t out_data
);
  import fdos_pkg::*;

  localparam int CNT_W = $clog2(MAX_FACES + 1);

  logic        accept;
  logic        out_accept;
  logic        ins_valid;
  fdos_ins_t   ins;
  logic        final_pending;
  logic        full;
  fdos_ctl_t   ctl;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             overflow_r, overflow_nxt;
  logic             drain_r, drain_nxt;

  fdos_entry_t cell_entry [MAX_FACES];
  logic        cell_ahead [MAX_FACES];
  logic        occ [MAX_FACES];

  assign accept     = in_valid & ~in_stall;
  assign out_accept = out_valid & ~out_stall;

  fdos_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_data       (in_data),
    .ins_valid     (ins_valid),
    .ins           (ins),
    .final_pending (final_pending)
  );

  assign full      = (count_r == CNT_W'(MAX_FACES));
  assign ctl.ins   = ins_valid & ~full;
  assign ctl.shift = out_accept;

  for (genvar g = 0; g < MAX_FACES; g++) begin : g_cell
    assign occ[g] = (CNT_W'(g) < count_r);
    if (g == 0) begin : g_head
      fdos_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occ[g]),
        .new_entry  (ins.entry),
        .prev_entry (ins.entry),
        .prev_ahead (1'b0),
        .next_entry (cell_entry[g+1]),
        .entry      (cell_entry[g]),
        .ahead      (cell_ahead[g])
      );
    end else if (g == MAX_FACES - 1) begin : g_tail
      fdos_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occ[g]),
        .new_entry  (ins.entry),
        .prev_entry (cell_entry[g-1]),
        .prev_ahead (cell_ahead[g-1]),
        .next_entry (cell_entry[g]),
        .entry      (cell_entry[g]),
        .ahead      (cell_ahead[g])
      );
    end else begin : g_mid
      fdos_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occ[g]),
        .new_entry  (ins.entry),
        .prev_entry (cell_entry[g-1]),
        .prev_ahead (cell_ahead[g-1]),
        .next_entry (cell_entry[g+1]),
        .entry      (cell_entry[g]),
        .ahead      (cell_ahead[g])
      );
    end
  end

  always_comb begin
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    drain_nxt    = drain_r;
    if (ins_valid) begin
      if (full) begin
        overflow_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (ins.final_face) begin
        drain_nxt = 1'b1;
      end
    end
    if (out_accept) begin
      count_nxt = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        drain_nxt    = 1'b0;
        overflow_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
      drain_r    <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
      drain_r    <= drain_nxt;
    end
  end

  assign in_stall  = final_pending | drain_r;
  assign out_valid = drain_r;

  assign out_data.sorted_face      = cell_entry[0].face;
  assign out_data.nearest_distance = cell_entry[0].nearest;
  assign out_data.dropped          = overflow_r;
  assign out_data.list_end         = (count_r == CNT_W'(1));

endmodule

### rtl/fdos_checker.sv
module fdos_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fdos_pkg::fdos_out_t out_data
);
  import fdos_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while list is emitted");

  a_list_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.list_end |=> out_valid)
    else $error("list emission broke off before list_end");

  a_list_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.list_end |=> !out_valid)
    else $error("result emitted after list_end");

endmodule

bind face_depth_order_sorter_top fdos_checker u_fdos_checker (.*);
